FILE: design/lbtb_pkg.sv
// Shared types and constants for the LED blink timer bank.
`timescale 1ns / 1ps

package lbtb_pkg;

	// Number of LED units in the bank (1 to 2, as the unit port is one bit wide)
	localparam int UNITS = 2;

	// Unit index width
	localparam int UIDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;

	// Number of units reported in the result fields
	localparam int REPORT = (UNITS < 2) ? UNITS : 2;

	// Field and state widths
	localparam int LEN_W   = 16;
	localparam int CNT_W   = 16;
	localparam int PHASE_W = 8;
	localparam int ON_W    = 17;

	// Length and count code that means forever
	localparam logic [LEN_W-1:0] FOREVER_CODE = '1;

	// Input function codes
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_ON    = 2'd1,
		FUNC_BLINK = 2'd2,
		FUNC_OFF   = 2'd3
	} func_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_RESP
	} state_t;

endpackage

FILE: design/led_blink_timer_bank.sv
// Top level of the LED blink timer bank: per-unit timer state and a unit-serial tick sequencer.
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   func, unit, length, blink_count
// out      source     out_valid/out_stall led_levels, active_mask
//
// A command is applied at the edge that accepts it; its result is shown the next cycle.
// A tick walks the units one per cycle through one shared tick unit, then shows the result.
// in_stall stays high from acceptance until the result transaction completes.
// arst_n clears every unit to dark and idle, with a phase length of one.
// A stalled result holds, as does all timer state, until out_stall drops.

module led_blink_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic        unit,
	input  logic [15:0] length,
	input  logic [15:0] blink_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  led_levels,
	output logic [1:0]  active_mask
);

	localparam int U   = lbtb_pkg::UNITS;
	localparam int IW  = lbtb_pkg::UIDX_W;
	localparam int PW  = lbtb_pkg::PHASE_W;
	localparam int OW  = lbtb_pkg::ON_W;
	localparam int CW  = lbtb_pkg::CNT_W;

	// Per-unit timer state
	logic          blink_mode_q   [U];
	logic          lit_phase_q    [U];
	logic [PW-1:0] phase_ticks_q  [U];
	logic [PW-1:0] phase_length_q [U];
	logic [CW-1:0] blinks_left_q  [U];
	logic [OW-1:0] on_remaining_q [U];
	logic          on_forever_q   [U];
	logic          pin_level_q    [U];

	lbtb_pkg::state_t state_q, state_d;
	logic [IW-1:0]    idx_q;

	logic          in_fire, out_fire, do_cmd, do_tick, last_unit, unit_ok;
	logic [IW-1:0] cmd_idx;

	// Shared tick unit results for the visited unit
	logic          hit;
	logic          lit_n, pin_n;
	logic [PW-1:0] pt_n;
	logic [CW-1:0] bl_n;
	logic [OW-1:0] onr_n;

	assign in_stall  = (state_q != lbtb_pkg::ST_IDLE);
	assign out_valid = (state_q == lbtb_pkg::ST_RESP);
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid && !out_stall;
	assign unit_ok   = (int'(unit) < U);
	assign cmd_idx   = IW'(unit);
	assign do_cmd    = in_fire && (func != lbtb_pkg::FUNC_TICK) && unit_ok;
	assign do_tick   = (state_q == lbtb_pkg::ST_TICK);
	assign last_unit = (idx_q == IW'(U - 1));

	// Sequence: accept, walk units on a tick, then present the result
	always_comb begin
		state_d = state_q;
		case (state_q)
			lbtb_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (func == lbtb_pkg::FUNC_TICK) ? lbtb_pkg::ST_TICK
						: lbtb_pkg::ST_RESP;
				end
			end
			lbtb_pkg::ST_TICK: begin
				if (last_unit) state_d = lbtb_pkg::ST_RESP;
			end
			lbtb_pkg::ST_RESP: begin
				if (out_fire) state_d = lbtb_pkg::ST_IDLE;
			end
			default: state_d = lbtb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbtb_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) idx_q <= '0;
			else if (do_tick && !last_unit) idx_q <= idx_q + 1'b1;
		end
	end

	// Run the tick rule of the visited unit
	always_comb begin
		hit   = (phase_ticks_q[idx_q] >= phase_length_q[idx_q]);
		lit_n = lit_phase_q[idx_q];
		pin_n = pin_level_q[idx_q];
		pt_n  = phase_ticks_q[idx_q];
		bl_n  = blinks_left_q[idx_q];
		onr_n = on_remaining_q[idx_q];
		if (blink_mode_q[idx_q]) begin
			pt_n = phase_ticks_q[idx_q] + 1'b1;
			if (hit) begin
				if (!lit_phase_q[idx_q]) begin
					if (blinks_left_q[idx_q] != '0) begin
						if (blinks_left_q[idx_q] != lbtb_pkg::FOREVER_CODE) begin
							bl_n = blinks_left_q[idx_q] - 1'b1;
						end
						pt_n  = '0;
						lit_n = 1'b1;
						pin_n = 1'b1;
					end
				end else begin
					pt_n  = '0;
					lit_n = 1'b0;
					pin_n = 1'b0;
				end
			end
		end else if (on_forever_q[idx_q]) begin
			pin_n = 1'b1;
		end else if (on_remaining_q[idx_q] != '0) begin
			onr_n = on_remaining_q[idx_q] - 1'b1;
			pin_n = 1'b1;
		end else begin
			pin_n = 1'b0;
		end
	end

	// Write back tick results or apply a command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < U; i++) begin
				blink_mode_q[i]   <= 1'b0;
				lit_phase_q[i]    <= 1'b0;
				phase_ticks_q[i]  <= '0;
				phase_length_q[i] <= PW'(1);
				blinks_left_q[i]  <= '0;
				on_remaining_q[i] <= '0;
				on_forever_q[i]   <= 1'b0;
				pin_level_q[i]    <= 1'b0;
			end
		end else if (do_tick) begin
			lit_phase_q[idx_q]    <= lit_n;
			pin_level_q[idx_q]    <= pin_n;
			phase_ticks_q[idx_q]  <= pt_n;
			blinks_left_q[idx_q]  <= bl_n;
			on_remaining_q[idx_q] <= onr_n;
		end else if (do_cmd) begin
			pin_level_q[cmd_idx] <= (func == lbtb_pkg::FUNC_ON)
				|| (func == lbtb_pkg::FUNC_BLINK);
			if (func == lbtb_pkg::FUNC_BLINK) begin
				blink_mode_q[cmd_idx]   <= 1'b1;
				blinks_left_q[cmd_idx]  <= blink_count;
				phase_length_q[cmd_idx] <= length[PW-1:0];
				on_remaining_q[cmd_idx] <= '0;
				on_forever_q[cmd_idx]   <= 1'b0;
			end else if (func == lbtb_pkg::FUNC_ON) begin
				blink_mode_q[cmd_idx]   <= 1'b0;
				on_remaining_q[cmd_idx] <= {length, 1'b0};
				on_forever_q[cmd_idx]   <= (length == lbtb_pkg::FOREVER_CODE);
				blinks_left_q[cmd_idx]  <= '0;
			end else begin
				blink_mode_q[cmd_idx]   <= 1'b0;
				on_remaining_q[cmd_idx] <= '0;
				on_forever_q[cmd_idx]   <= 1'b0;
				blinks_left_q[cmd_idx]  <= '0;
			end
		end
	end

	// Report pin levels and activity of the first units
	always_comb begin
		led_levels  = '0;
		active_mask = '0;
		for (int u = 0; u < lbtb_pkg::REPORT; u++) begin
			led_levels[u]  = pin_level_q[u];
			active_mask[u] = (on_remaining_q[u] != '0) || (blinks_left_q[u] != '0);
		end
	end

	// A command result follows its transaction in the next cycle
	a_cmd_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func != lbtb_pkg::FUNC_TICK) |=> out_valid)
		else $error("command result not presented");

	// A tick starts the unit walk at unit zero
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && func == lbtb_pkg::FUNC_TICK) |=> (do_tick && idx_q == '0))
		else $error("tick walk did not start");

	// The walk never visits a unit beyond the bank
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		do_tick |-> (int'(idx_q) < U))
		else $error("unit index out of range");

	// The walk ends with the result after the last unit
	a_tick_end: assert property (@(posedge clk) disable iff (!arst_n)
		(do_tick && last_unit) |=> out_valid)
		else $error("tick walk did not end in a result");

	// Timer state holds while a result waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(led_levels) && $stable(active_mask)))
		else $error("result changed while stalled");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the LED blink timer bank: directed, sequenced and random traffic.
`timescale 1ns / 1ps

module tb;
	import lbtb_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [1:0] levels;
		logic [1:0] active;
	} led_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_TICK;
	logic        unit = 1'b0;
	logic [15:0] length = '0;
	logic [15:0] blink_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  led_levels;
	logic [1:0]  active_mask;

	// Predicted timer state, one entry per unit
	logic              blink_on   [UNITS];
	logic              lit        [UNITS];
	logic [PHASE_W-1:0] phase_cnt [UNITS];
	logic [PHASE_W-1:0] phase_len [UNITS];
	logic [CNT_W-1:0]  blinks_rem [UNITS];
	logic [ON_W-1:0]   on_left    [UNITS];
	logic              forever_on [UNITS];
	logic              pin        [UNITS];

	led_status_t pending_status [$];

	int errors = 0;
	int sent = 0;
	int checked = 0;
	int ticks_seen = 0;
	int cmds_seen = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	led_blink_timer_bank uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.unit(unit),
		.length(length),
		.blink_count(blink_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.led_levels(led_levels),
		.active_mask(active_mask)
	);

	always #5 clk = ~clk;

	// Put every predicted unit in its reset state
	function automatic void clear_timers();
		int i;
		for (i = 0; i < UNITS; i++) begin
			blink_on[i] = 1'b0;
			lit[i] = 1'b0;
			phase_cnt[i] = '0;
			phase_len[i] = PHASE_W'(1);
			blinks_rem[i] = '0;
			on_left[i] = '0;
			forever_on[i] = 1'b0;
			pin[i] = 1'b0;
		end
	endfunction

	// Apply one transaction to the predicted timers and return the LED status it shows
	function automatic led_status_t advance_timers(func_t f, logic u, logic [15:0] len,
			logic [15:0] cnt);
		led_status_t st;
		logic [PHASE_W-1:0] old;
		logic [LEN_W-1:0] solid_len;
		int i;
		st = '0;
		if (f == FUNC_TICK) begin
			for (i = 0; i < UNITS; i++) begin
				if (blink_on[i]) begin
					old = phase_cnt[i];
					phase_cnt[i] = old + 1'b1;
					if (old >= phase_len[i]) begin
						if (!lit[i]) begin
							// Start a lit phase only while blinks remain
							if (blinks_rem[i] != 0) begin
								if (blinks_rem[i] != FOREVER_CODE)
									blinks_rem[i] = blinks_rem[i] - 1'b1;
								phase_cnt[i] = '0;
								lit[i] = 1'b1;
								pin[i] = 1'b1;
							end
						end else begin
							phase_cnt[i] = '0;
							lit[i] = 1'b0;
							pin[i] = 1'b0;
						end
					end
				end else if (forever_on[i]) begin
					pin[i] = 1'b1;
				end else if (on_left[i] != 0) begin
					on_left[i] = on_left[i] - 1'b1;
					pin[i] = 1'b1;
				end else begin
					pin[i] = 1'b0;
				end
			end
		end else if (int'(u) < UNITS) begin
			pin[u] = (f == FUNC_ON) || (f == FUNC_BLINK);
			if (f == FUNC_BLINK) begin
				blink_on[u] = 1'b1;
				blinks_rem[u] = cnt;
				phase_len[u] = len[PHASE_W-1:0];
				on_left[u] = '0;
				forever_on[u] = 1'b0;
			end else begin
				solid_len = (f == FUNC_ON) ? len : '0;
				blink_on[u] = 1'b0;
				on_left[u] = {solid_len, 1'b0};
				forever_on[u] = (solid_len == FOREVER_CODE);
				blinks_rem[u] = '0;
			end
		end
		for (i = 0; i < REPORT; i++) begin
			st.levels[i] = pin[i];
			st.active[i] = (on_left[i] != 0) || (blinks_rem[i] != 0);
		end
		return st;
	endfunction

	// Check each result transaction, then predict each accepted input transaction
	always @(posedge clk) begin : scoreboard
		led_status_t exp_st;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					errors++;
					$display("%0t: unexpected result levels=%b active=%b", $time,
						led_levels, active_mask);
				end else begin
					exp_st = pending_status.pop_front();
					checked++;
					if (led_levels !== exp_st.levels) begin
						errors++;
						$display("%0t: led_levels expected %b got %b", $time,
							exp_st.levels, led_levels);
					end
					if (active_mask !== exp_st.active) begin
						errors++;
						$display("%0t: active_mask expected %b got %b", $time,
							exp_st.active, active_mask);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func_t'(func) == FUNC_TICK)
					ticks_seen++;
				else
					cmds_seen++;
				pending_status.push_back(advance_timers(func_t'(func), unit, length,
					blink_count));
			end
		end
	end

	// Stall the result channel in modes: open, light random, heavy random
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Bound the run length
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Send one transaction, opening a new burst after a random gap when the last one ran out
	task automatic send_item(func_t f, logic u, logic [15:0] len, logic [15:0] cnt);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		unit <= u;
		length <= len;
		blink_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// Send a tick with junk in the ignored fields
	task automatic send_tick();
		send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
	endtask

	// Hold off the sender until every predicted result has arrived
	task automatic wait_all_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (UNITS + 4) @(posedge clk);
	endtask

	// Field extremes, each command, forever codes and the early-lit blink
	task automatic test_directed();
		send_tick();
		send_item(FUNC_ON, 1'b0, 16'h0000, 16'hFFFF);
		send_tick();
		send_item(FUNC_ON, 1'b0, 16'h0001, 16'h0000);
		repeat (3) send_tick();
		send_item(FUNC_ON, 1'b1, FOREVER_CODE, 16'h0000);
		send_tick();
		// Blink with no blinks: pin lights at once and stays lit while dark
		send_item(FUNC_BLINK, 1'b0, 16'h0100, 16'h0000);
		send_tick();
		send_item(FUNC_BLINK, 1'b0, 16'hFF01, 16'h0002);
		repeat (4) send_tick();
		send_item(FUNC_BLINK, 1'b1, 16'hFFFF, FOREVER_CODE);
		repeat (2) send_tick();
		send_item(FUNC_OFF, 1'b1, 16'hFFFF, 16'hFFFF);
		send_item(FUNC_OFF, 1'b0, 16'h0000, 16'h0000);
		send_item(FUNC_ON, 1'b1, 16'h8000, 16'h5555);
		send_tick();
		send_item(FUNC_ON, 1'b1, 16'hFFFE, 16'hAAAA);
		send_tick();
	endtask

	// Blink commands followed by runs of ticks, with small phases so phases turn often
	task automatic test_blink_runs(int upto);
		logic [15:0] len;
		logic [15:0] cnt;
		logic u;
		int n;
		// Let the phase counter wrap while dark, then reload blinks over it
		send_item(FUNC_BLINK, 1'b0, 16'h0000, 16'h0000);
		repeat ($urandom_range(250, 320)) send_tick();
		send_item(FUNC_BLINK, 1'b0, 16'h0080, 16'h0002);
		repeat (20) send_tick();
		while (sent < upto) begin
			u = 1'($urandom_range(0, 1));
			len[15:8] = 8'($urandom_range(0, 255));
			len[7:0] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 5));
			case ($urandom_range(0, 7))
				0: cnt = FOREVER_CODE;
				1: cnt = 16'($urandom_range(0, 65535));
				default: cnt = 16'($urandom_range(0, 3));
			endcase
			send_item(FUNC_BLINK, u, len, cnt);
			n = $urandom_range(1, 20);
			repeat (n) begin
				// Drop in an occasional command on either unit
				if ($urandom_range(0, 15) == 0)
					send_item(func_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
						16'($urandom_range(0, 7)), 16'($urandom_range(0, 3)));
				else
					send_tick();
			end
		end
	endtask

	// Solid-on commands with short lengths that expire, plus forever and off
	task automatic test_solid_runs(int upto);
		logic [15:0] len;
		int n;
		while (sent < upto) begin
			case ($urandom_range(0, 7))
				0: len = FOREVER_CODE;
				1: len = 16'($urandom_range(0, 65535));
				default: len = 16'($urandom_range(0, 6));
			endcase
			if ($urandom_range(0, 5) == 0)
				send_item(FUNC_OFF, 1'($urandom_range(0, 1)), len,
					16'($urandom_range(0, 65535)));
			else
				send_item(FUNC_ON, 1'($urandom_range(0, 1)), len,
					16'($urandom_range(0, 65535)));
			n = $urandom_range(1, 16);
			repeat (n) send_tick();
		end
	endtask

	// Fully random transactions
	task automatic test_random_mix(int upto);
		while (sent < upto)
			send_item(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		clear_timers();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_all_results();
		test_blink_runs(900);
		wait_all_results();
		test_solid_runs(1400);
		wait_all_results();
		test_random_mix(1975);
		wait_all_results();
		$display("tb: %0d transactions sent (%0d ticks, %0d commands), %0d results checked",
			sent, ticks_seen, cmds_seen, checked);
		$display("tb: covered blink phases, counter wrap, solid expiry, forever codes, off");
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: led_blink_timer_bank.f
design/lbtb_pkg.sv
design/led_blink_timer_bank.sv
tb/tb.sv
